### rtl/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
package pfa_pkg;

	localparam int MAX_PAGES  = 4096;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = 24;
	localparam int CNT_W      = 13;
	localparam int IDX_W      = $clog2(MAX_PAGES);
	localparam int CFG_IDX_W  = 1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = CFG_IDX_W'(1);

	localparam logic [CNT_W-1:0] TOTAL_RESET    = CNT_W'(4096);
	localparam logic [CNT_W-1:0] RESERVED_RESET = CNT_W'(256);

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_OOM        = 3'd1,
		ST_MISALIGNED = 3'd2,
		ST_RANGE      = 3'd3,
		ST_NOT_ALLOC  = 3'd4
	} status_t;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] page_address;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] granted_address;
		logic [CNT_W-1:0]  free_count;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    clear;
		logic    scan;
		logic    fread;
		logic    grant;
		logic    release_pg;
		logic    res_we;
		status_t res_code;
		logic    publish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic hit;
		logic exhausted;
		logic misaligned;
		logic out_range;
		logic frame_set;
	} sts_t;

endpackage

### rtl/pfa_ctrl.sv
// Sequencer for clear pass, allocate scan and free check.
module pfa_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        func,
	input  pfa_pkg::sts_t sts,
	output pfa_pkg::cmd_t cmd,
	output logic        busy
);
	import pfa_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_FCHK  = 6'b001000,
		S_FTST  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_code = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (func == FUNC_FREE) ? S_FCHK : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.grant  = 1'b1;
					cmd.res_we = 1'b1;
					state_d    = S_FIN;
				end else if (sts.exhausted) begin
					cmd.res_we   = 1'b1;
					cmd.res_code = ST_OOM;
					state_d      = S_FIN;
				end
			end
			S_FCHK: begin
				cmd.fread = 1'b1;
				// alignment first, then range
				if (sts.misaligned) begin
					cmd.res_we   = 1'b1;
					cmd.res_code = ST_MISALIGNED;
					state_d      = S_FIN;
				end else if (sts.out_range) begin
					cmd.res_we   = 1'b1;
					cmd.res_code = ST_RANGE;
					state_d      = S_FIN;
				end else begin
					state_d = S_FTST;
				end
			end
			S_FTST: begin
				cmd.res_we = 1'b1;
				if (sts.frame_set) begin
					cmd.release_pg = 1'b1;
				end else begin
					cmd.res_code = ST_NOT_ALLOC;
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.publish = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

### rtl/pfa_dpath.sv
// Page-use store, scan pointer, use counter, config and result registers.
module pfa_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfa_pkg::req_t                 req,
	input  logic                          cfg_valid,
	input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfa_pkg::CNT_W-1:0]     cfg_data,
	input  pfa_pkg::cmd_t                 cmd,
	output pfa_pkg::sts_t                 sts,
	output logic                          done,
	output pfa_pkg::rsp_t                 result
);
	import pfa_pkg::*;

	localparam logic [CNT_W-1:0] MAX_PAGES_C = CNT_W'(MAX_PAGES);
	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(MAX_PAGES - 1);

	// one in-use bit per page; counts only ever hold zero or one
	logic mem [MAX_PAGES];

	logic [CNT_W-1:0]  total_q, reserved_q, used_q, scan_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  clr_q, rd_idx_s1;
	logic              rd_data_s1, pend_s1;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              done_q;
	rsp_t              result_q;

	logic [CNT_W-1:0]  hi, span, free_now;
	logic [IDX_W-1:0]  fidx, rd_addr, wr_addr;
	logic [CNT_W-1:0]  fidx_ext;
	logic              scan_more, issue, rd_en, wr_en, wr_data;

	assign hi        = (total_q < MAX_PAGES_C) ? total_q : MAX_PAGES_C;
	assign span      = (hi > reserved_q) ? (hi - reserved_q) : '0;
	assign free_now  = (span > used_q) ? (span - used_q) : '0;
	assign scan_more = (scan_q < hi);
	assign issue     = cmd.scan && scan_more;
	assign fidx      = IDX_W'(addr_q[ADDR_W-1:PAGE_SHIFT]);
	assign fidx_ext  = CNT_W'(fidx);
	assign rd_en     = issue || cmd.fread;
	assign rd_addr   = cmd.fread ? fidx : scan_q[IDX_W-1:0];

	assign sts.clr_last   = (clr_q == LAST_IDX);
	assign sts.hit        = pend_s1 && !rd_data_s1;
	assign sts.exhausted  = !pend_s1 && !scan_more;
	assign sts.misaligned = |addr_q[PAGE_SHIFT-1:0];
	assign sts.out_range  = (fidx_ext < reserved_q) || (fidx_ext >= hi);
	assign sts.frame_set  = rd_data_s1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = 1'b0;
		priority if (cmd.clear) begin
			wr_en = 1'b1;
		end else if (cmd.grant) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
			wr_data = 1'b1;
		end else if (cmd.release_pg) begin
			wr_en   = 1'b1;
			wr_addr = fidx;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (issue) begin
			rd_idx_s1 <= scan_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RESET;
			reserved_q <= RESERVED_RESET;
			used_q     <= '0;
			clr_q      <= '0;
			pend_s1    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TOTAL_PAGES:    total_q    <= cfg_data;
					CFG_RESERVED_PAGES: reserved_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load) begin
				pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				pend_s1 <= issue;
			end
			if (cmd.grant) begin
				used_q <= used_q + 1'b1;
			end else if (cmd.release_pg && (used_q != '0)) begin
				used_q <= used_q - 1'b1;
			end
			done_q <= cmd.publish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= req.page_address;
			scan_q <= reserved_q;
		end else if (issue) begin
			scan_q <= scan_q + 1'b1;
		end
		if (cmd.res_we) begin
			res_status_q <= cmd.res_code;
			res_addr_q   <= cmd.grant ? ADDR_W'({rd_idx_s1, {PAGE_SHIFT{1'b0}}}) : '0;
		end
		if (cmd.publish) begin
			result_q.status          <= res_status_q;
			result_q.granted_address <= res_addr_q;
			result_q.free_count      <= free_now;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### rtl/page_frame_allocator_core.sv
// Top level of the first-fit page frame allocator.
//
// Allocates and frees 4 KiB physical page frames. A request is taken when
// start is high and busy is low. Its result appears on result for exactly
// one cycle with done high and cannot be held off, so capture it on that
// edge. An allocate walks the page-use store upward from reserved_pages,
// one page per cycle through the single read port of the store, and grants
// the lowest free page, or stops at the top of the window when memory is
// exhausted. A free does its check and store read, then the update; a free
// that fails the alignment or range check ends after the check.
// After reset the block clears the 4096-entry store, one entry per cycle,
// and holds busy high until the clearing pass is over.
// Configuration writes are always taken (cfg_ready is tied high) but must
// only be issued while the block is idle.
module page_frame_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  pfa_pkg::req_t                 req,
	// result channel
	output logic                          done,
	output pfa_pkg::rsp_t                 result,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfa_pkg::CNT_W-1:0]     cfg_data
);
	import pfa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: clear pass, scan loop, free check
	pfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// store, counters and result registers
	pfa_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule

### rtl/pfa_checker.sv
// Port-level checks for the page frame allocator, bound to the top level.
module pfa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input pfa_pkg::rsp_t result
);
	import pfa_pkg::*;

	// a result is only shown once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// one strobe per request, never two in a row
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// an accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request transfer did not raise busy");

	// failed requests grant nothing
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.granted_address == '0))
		else $error("address granted on a failed request");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);

### dv/page_frame_allocator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the page frame allocator core.
module page_frame_allocator_core_tb;
	import pfa_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	req_t                 req;
	logic                 done;
	rsp_t                 result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	page_frame_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the allocator: per-page use counts, pages in use and the window registers.
	logic [7:0]       frame_refs [MAX_PAGES];
	int unsigned      pages_in_use;
	logic [CNT_W-1:0] win_total;
	logic [CNT_W-1:0] win_reserved;

	// Outcomes still owed by the block, oldest first, and pages we currently hold.
	rsp_t        due_outcomes [$];
	int unsigned held_pages [$];

	int errors;
	int n_results;
	int n_alloc;
	int n_free;
	int n_cfg_writes;
	int seen_status [5];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [ADDR_W-1:0] page_addr(input int unsigned pg);
		return ADDR_W'(pg << PAGE_SHIFT);
	endfunction

	// Scan and range limit: win_total clamped to the size of the store.
	function automatic int unsigned window_top();
		return (win_total < MAX_PAGES) ? win_total : MAX_PAGES;
	endfunction

	// Applies one request to the shadow state and returns the outcome the block owes.
	function automatic rsp_t apply_frame_op(input req_t r);
		rsp_t        o;
		int unsigned top;
		int unsigned pg;
		int unsigned span;
		top               = window_top();
		o.status          = ST_OK;
		o.granted_address = '0;
		if (r.func == FUNC_ALLOC) begin
			// first fit: lowest unused page at or above the reserved area
			pg = win_reserved;
			while (pg < top && frame_refs[pg] != 8'd0)
				pg++;
			if (pg < top) begin
				frame_refs[pg]    = 8'd1;
				pages_in_use++;
				o.granted_address = page_addr(pg);
			end else begin
				o.status = ST_OOM;
			end
		end else begin
			// alignment first, then range, then use count; a rejected free changes nothing
			pg = r.page_address >> PAGE_SHIFT;
			if (r.page_address[PAGE_SHIFT-1:0] != '0) begin
				o.status = ST_MISALIGNED;
			end else if (pg < win_reserved || pg >= top) begin
				o.status = ST_RANGE;
			end else if (frame_refs[pg] == 8'd0) begin
				o.status = ST_NOT_ALLOC;
			end else begin
				frame_refs[pg]--;
				if (frame_refs[pg] == 8'd0 && pages_in_use > 0)
					pages_in_use--;
			end
		end
		// pages held outside a shrunk window still count, so this saturates at zero
		span         = (top > win_reserved) ? top - win_reserved : 0;
		o.free_count = CNT_W'((span > pages_in_use) ? span - pages_in_use : 0);
		return o;
	endfunction

	// Presents one request and returns at the edge that takes it. start stays high
	// so the next request of a burst follows without a bubble.
	task automatic send_req(input logic func, input logic [ADDR_W-1:0] addr);
		req_t        r;
		rsp_t        want;
		int unsigned pg;
		int          hit [$];
		r = '{func: func, page_address: addr};
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		want = apply_frame_op(r);
		due_outcomes.push_back(want);
		if (func == FUNC_ALLOC)
			n_alloc++;
		else
			n_free++;
		if (want.status == ST_OK) begin
			if (func == FUNC_ALLOC) begin
				held_pages.push_back(want.granted_address >> PAGE_SHIFT);
			end else begin
				pg  = addr >> PAGE_SHIFT;
				hit = held_pages.find_first_index(x) with (x == pg);
				if (hit.size() != 0)
					held_pages.delete(hit[0]);
			end
		end
	endtask

	task automatic pause_sender(input int unsigned cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Holds off until every owed outcome has arrived and the block is idle.
	task automatic wait_drained();
		pause_sender(0);
		while (due_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TOTAL_PAGES:    win_total    = val;
			CFG_RESERVED_PAGES: win_reserved = val;
			default: ;
		endcase
		n_cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_window(input int unsigned total, input int unsigned reserved);
		wait_drained();
		write_cfg(CFG_TOTAL_PAGES, CNT_W'(total));
		write_cfg(CFG_RESERVED_PAGES, CNT_W'(reserved));
	endtask

	// Result side: every done strobe is one transfer, compared with the oldest owed outcome.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			n_results++;
			if (due_outcomes.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing owed: %p",
					n_results, result));
			end else begin
				want = due_outcomes.pop_front();
				seen_status[int'(want.status)]++;
				if (result.status !== want.status)
					report_mismatch($sformatf("result %0d status %0d, expected %0d",
						n_results, result.status, want.status));
				if (result.granted_address !== want.granted_address)
					report_mismatch($sformatf("result %0d granted_address %h, expected %h",
						n_results, result.granted_address, want.granted_address));
				if (result.free_count !== want.free_count)
					report_mismatch($sformatf("result %0d free_count %0d, expected %0d",
						n_results, result.free_count, want.free_count));
			end
		end
	end

	// Reset window: first-fit from page 256, every rejection reason of a free.
	task automatic test_default_window();
		send_req(FUNC_ALLOC, 24'hFFFFFF);       // address is ignored on allocate
		send_req(FUNC_ALLOC, 24'h000000);
		send_req(FUNC_FREE, 24'h000000);        // aligned but reserved
		send_req(FUNC_FREE, 24'hFFFFFF);        // misaligned beats everything
		send_req(FUNC_FREE, 24'h000001);
		send_req(FUNC_FREE, 24'h100800);
		send_req(FUNC_FREE, page_addr(MAX_PAGES - 1));  // in range, never handed out
		send_req(FUNC_FREE, page_addr(255));    // just below the window
		send_req(FUNC_FREE, page_addr(256));
		send_req(FUNC_ALLOC, 24'h5A5A5A);       // first fit hands 256 back
		send_req(FUNC_FREE, page_addr(257));
		send_req(FUNC_FREE, page_addr(257));    // double free
		pause_sender(3);
	endtask

	// Window corners: clamped total, reserved zero, exhaustion, empty windows.
	task automatic test_window_edges();
		// total past the store is clamped; one-page window at the very top
		set_window(8191, MAX_PAGES - 1);
		send_req(FUNC_ALLOC, 24'h000000);
		send_req(FUNC_ALLOC, 24'h000000);       // full
		send_req(FUNC_FREE, page_addr(MAX_PAGES - 1));

		// page 0 is usable; fill four pages, then probe the top edge and reuse a hole
		set_window(4, 0);
		repeat (5) send_req(FUNC_ALLOC, ADDR_W'($urandom));
		send_req(FUNC_FREE, page_addr(4));
		send_req(FUNC_FREE, page_addr(2));
		send_req(FUNC_ALLOC, ADDR_W'($urandom));

		// nothing managed at all
		set_window(0, 0);
		send_req(FUNC_ALLOC, 24'h000000);
		send_req(FUNC_FREE, page_addr(0));

		// reserved above total
		set_window(16, 20);
		send_req(FUNC_ALLOC, 24'hFFFFFF);
	endtask

	// Mostly allocate / free-of-a-held-page traffic, with stray and broken frees mixed in.
	task automatic random_item();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			send_req(FUNC_ALLOC, ADDR_W'($urandom));
		else if (roll < 75 && held_pages.size() != 0)
			send_req(FUNC_FREE, page_addr(held_pages[$urandom_range(0, held_pages.size() - 1)]));
		else if (roll < 85)
			send_req(FUNC_FREE, page_addr($urandom_range(0, MAX_PAGES - 1)));
		else if (roll < 92)
			send_req(FUNC_FREE, page_addr($urandom_range(0, MAX_PAGES - 1)) |
				ADDR_W'($urandom_range(1, (1 << PAGE_SHIFT) - 1)));
		else
			send_req(FUNC_FREE, ADDR_W'($urandom));
	endtask

	// Random traffic across several windows, sent in bursts with random gaps.
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned phase_total [7] = '{4096, 24, 8191, 300, 12, 64, 4096};
		int unsigned phase_res   [7] = '{256, 8, 4080, 0, 20, 60, 0};
		int unsigned per_phase;
		int unsigned sent;
		int unsigned burst;
		per_phase = n_items / 7;
		for (int p = 0; p < 7; p++) begin
			set_window(phase_total[p], phase_res[p]);
			sent = 0;
			while (sent < per_phase) begin
				burst = $urandom_range(1, 6);
				for (int b = 0; b < burst && sent < per_phase; b++) begin
					random_item();
					sent++;
				end
				// sometimes run straight on, otherwise idle a few cycles
				if ($urandom_range(0, 3) != 0)
					pause_sender($urandom_range(0, 7));
				// once, mid-phase, let the block run completely dry
				if (p == 3 && sent >= per_phase / 2 && sent < per_phase / 2 + burst)
					wait_drained();
			end
		end
	endtask

	task automatic finish_drain();
		int unsigned waited;
		pause_sender(0);
		waited = 0;
		// longest single request is a full-store scan
		while (due_outcomes.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (due_outcomes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", due_outcomes.size()));
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		win_total    = TOTAL_RESET;
		win_reserved = RESERVED_RESET;
		pages_in_use = 0;
		foreach (frame_refs[i])
			frame_refs[i] = 8'd0;
		foreach (seen_status[i])
			seen_status[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the store clearing pass after reset shows up as busy; send_req waits it out
		test_default_window();
		test_window_edges();
		test_random_traffic(112);
		finish_drain();

		$display("run: %0d allocate and %0d free transfers, %0d register writes",
			n_alloc, n_free, n_cfg_writes);
		$display("outcomes: ok %0d, out of memory %0d, misaligned %0d, range %0d, unheld %0d",
			seen_status[ST_OK], seen_status[ST_OOM], seen_status[ST_MISALIGNED],
			seen_status[ST_RANGE], seen_status[ST_NOT_ALLOC]);
		if (errors == 0)
			$display("page_frame_allocator_core_tb: clean");
		else
			$display("page_frame_allocator_core_tb: errors");
		$finish;
	end

	// Watchdog: clearing pass plus every request as a full-store scan, several times over.
	initial begin
		#40_000_000;
		$display("page_frame_allocator_core_tb: errors");
		$finish;
	end

endmodule
